[sv/assert_macros.svh]
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition never true at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[sv/lpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

	localparam int unsigned HDR_BYTES      = 8;
	localparam int unsigned KIND_OFFSET    = 4;
	localparam int unsigned VERSION_OFFSET = 6;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KIND_COUNT  = 2'd1;

	localparam logic [31:0] MAX_PAYLOAD_RST = 32'd65536;
	localparam logic [15:0] KIND_COUNT_RST  = 16'd23;

	typedef enum logic [1:0] {
		ST_HEADER  = 2'd0,
		ST_PAYLOAD = 2'd1,
		ST_FATAL   = 2'd2,
		ST_DISCARD = 2'd3
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  out_byte;
		logic [15:0] msg_kind;
		logic [15:0] frame_version;
		logic [31:0] frame_length;
		logic        frame_end;
	} result_t;

endpackage

`default_nettype wire

[sv/lpd_byte_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

[sv/lpd_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lpd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  out_byte;
	logic [15:0] msg_kind;
	logic [15:0] frame_version;
	logic [31:0] frame_length;
	logic        frame_end;

	modport source (
		output valid, output status, output out_byte, output msg_kind,
		output frame_version, output frame_length, output frame_end,
		input ready
	);
	modport sink (
		input valid, input status, input out_byte, input msg_kind,
		input frame_version, input frame_length, input frame_end,
		output ready
	);
endinterface

`default_nettype wire

[sv/lpd_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lpd_tracker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lpd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           accept,
	input  wire logic [7:0]                     data_byte,
	output lpd_pkg::result_t                    res
);

	logic [31:0] max_payload_q;
	logic [15:0] kind_count_q;

	logic [2:0]  hdr_cnt_q;
	logic [63:0] hdr_bytes_q;
	logic [31:0] payload_left_q;
	logic        in_payload_q;
	logic        fatal_q;

	logic [2:0]  pos;
	logic [63:0] hdr_base;
	logic [63:0] hdr_next;
	logic [63:0] hdr_view;
	logic        hdr_done;
	logic [31:0] len;
	logic [15:0] kind_raw;
	logic [15:0] kind;
	logic [15:0] version;
	logic [31:0] left_dec;
	logic        too_long;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= lpd_pkg::MAX_PAYLOAD_RST;
			kind_count_q  <= lpd_pkg::KIND_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lpd_pkg::CFG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				lpd_pkg::CFG_KIND_COUNT:  kind_count_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// header lane insert; the first byte of a header starts from a clean word
	always_comb begin
		pos      = hdr_cnt_q;
		hdr_base = (pos == 3'd0) ? 64'd0 : hdr_bytes_q;
		for (int i = 0; i < int'(lpd_pkg::HDR_BYTES); i++) begin
			hdr_next[8*i +: 8] = (pos == 3'(i)) ? data_byte : hdr_base[8*i +: 8];
		end
		hdr_done = (pos == 3'(lpd_pkg::HDR_BYTES - 1));
		hdr_view = in_payload_q ? hdr_bytes_q : hdr_next;
		len      = hdr_view[31:0];
		kind_raw = hdr_view[8*lpd_pkg::KIND_OFFSET +: 16];
		version  = hdr_view[8*lpd_pkg::VERSION_OFFSET +: 16];
		kind     = (kind_raw < kind_count_q) ? kind_raw : 16'd0;
		left_dec = payload_left_q - {31'd0, (payload_left_q != 32'd0)};
		too_long = (len > max_payload_q);
	end

	always_comb begin
		res               = '0;
		res.out_byte      = data_byte;
		res.status        = lpd_pkg::ST_HEADER;
		if (fatal_q) begin
			res.status = lpd_pkg::ST_DISCARD;
		end else if (in_payload_q) begin
			res.status        = lpd_pkg::ST_PAYLOAD;
			res.msg_kind      = kind;
			res.frame_version = version;
			res.frame_length  = len;
			res.frame_end     = (left_dec == 32'd0);
		end else if (hdr_done) begin
			res.msg_kind      = kind;
			res.frame_version = version;
			res.frame_length  = len;
			if (too_long) begin
				res.status = lpd_pkg::ST_FATAL;
			end else begin
				res.frame_end = (len == 32'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q      <= '0;
			payload_left_q <= '0;
			in_payload_q   <= 1'b0;
			fatal_q        <= 1'b0;
		end else if (accept && !fatal_q) begin
			if (in_payload_q) begin
				payload_left_q <= left_dec;
				if (left_dec == 32'd0) begin
					in_payload_q <= 1'b0;
					hdr_cnt_q    <= '0;
				end
			end else begin
				// wraps to zero on the last header byte
				hdr_cnt_q <= 3'(pos + 3'd1);
				if (hdr_done) begin
					if (too_long) begin
						fatal_q <= 1'b1;
					end else begin
						payload_left_q <= len;
						in_payload_q   <= (len != 32'd0);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !fatal_q && !in_payload_q) begin
			hdr_bytes_q <= hdr_next;
		end
	end

	`ASSERT_CLK(a_fatal_sticky, fatal_q |=> fatal_q, "fatal state cleared without reset")
	`ASSERT_NEVER(a_payload_nonzero, in_payload_q && (payload_left_q == 32'd0),
		"payload phase with nothing left")
	`ASSERT_NEVER(a_payload_hdr_idle, in_payload_q && (hdr_cnt_q != 3'd0),
		"header count moved during payload")

endmodule

`default_nettype wire

[sv/lpd_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module lpd_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire lpd_pkg::result_t res_d,
	output logic                  can_load,
	lpd_result_if.source          result_ch
);

	logic             valid_q;
	lpd_pkg::result_t res_q;

	// a new request may enter when the slot is empty or drains this cycle
	assign can_load = !valid_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res_d;
		end
	end

	assign result_ch.valid         = valid_q;
	assign result_ch.status        = res_q.status;
	assign result_ch.out_byte      = res_q.out_byte;
	assign result_ch.msg_kind      = res_q.msg_kind;
	assign result_ch.frame_version = res_q.frame_version;
	assign result_ch.frame_length  = res_q.frame_length;
	assign result_ch.frame_end     = res_q.frame_end;

endmodule

`default_nettype wire

[sv/length_prefixed_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none

// each accepted byte's result is registered and appears on result_ch in the cycle after it is accepted
// throughput: one byte per cycle; input stalls only while a held result waits for ready
// ready stays high while the output register is empty or being drained
// reset clears all frame state and the fatal latch, loads register defaults
// (max_payload 65536, kind_count 23); the byte pipeline holds no data after reset

module length_prefixed_deframer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lpd_pkg::CFG_DATA_W-1:0] cfg_data,
	lpd_byte_if.sink                            byte_ch,
	lpd_result_if.source                        result_ch
);

	logic             can_load;
	logic             accept;
	lpd_pkg::result_t res;

	assign byte_ch.ready = can_load;
	assign accept        = byte_ch.valid && can_load;

	lpd_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.data_byte (byte_ch.data_byte),
		.res       (res)
	);

	lpd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_d     (res),
		.can_load  (can_load),
		.result_ch (result_ch)
	);

endmodule

`default_nettype wire

[tb/sv/length_prefixed_deframer_test.sv]
`timescale 1ns / 1ps

module length_prefixed_deframer_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BYTES   = 690;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lpd_pkg::CFG_DATA_W-1:0] cfg_data;

	lpd_byte_if   byte_ch();
	lpd_result_if result_ch();

	length_prefixed_deframer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	// deframer state as the block should hold it
	logic [3:0]  rx_hdr_count;
	logic [63:0] rx_hdr;
	logic [31:0] rx_left;
	logic        rx_in_payload;
	logic        rx_fatal;
	logic [31:0] reg_max_payload;
	logic [15:0] reg_kind_count;

	lpd_pkg::result_t expected_results[$];
	int               errors;
	int               sent_bytes;
	int               quiet_cycles;
	int               sink_hold;
	bit               src_burst;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic lpd_pkg::result_t deframe_byte(input logic [7:0] b);
		lpd_pkg::result_t r;
		int               pos;
		logic [15:0]      kind;
		r = '0;
		r.status = lpd_pkg::ST_HEADER;
		r.out_byte = b;
		if (rx_fatal) begin
			r.status = lpd_pkg::ST_DISCARD;
			return r;
		end
		if (!rx_in_payload) begin
			pos = int'(rx_hdr_count[2:0]);
			if (pos == 0)
				rx_hdr = '0;
			rx_hdr[8*pos +: 8] = b;
			rx_hdr_count = 4'(pos + 1);
			// fields stay zero until the last header byte
			if (rx_hdr_count < lpd_pkg::HDR_BYTES)
				return r;
			rx_hdr_count = '0;
		end
		kind = rx_hdr[8*lpd_pkg::KIND_OFFSET +: 16];
		r.msg_kind = (kind < reg_kind_count) ? kind : 16'd0;
		r.frame_version = rx_hdr[8*lpd_pkg::VERSION_OFFSET +: 16];
		r.frame_length = rx_hdr[31:0];
		if (rx_in_payload) begin
			r.status = lpd_pkg::ST_PAYLOAD;
			if (rx_left > 0)
				rx_left = rx_left - 32'd1;
			if (rx_left == 0) begin
				r.frame_end = 1'b1;
				rx_in_payload = 1'b0;
				rx_hdr_count = '0;
			end
		end else if (rx_hdr[31:0] > reg_max_payload) begin
			r.status = lpd_pkg::ST_FATAL;
			rx_fatal = 1'b1;
		end else begin
			rx_left = rx_hdr[31:0];
			if (rx_left == 0)
				r.frame_end = 1'b1;
			else
				rx_in_payload = 1'b1;
		end
		return r;
	endfunction

	function automatic void expect_result(input lpd_pkg::result_t r);
		expected_results = {expected_results, r};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endfunction

	// called at a rising edge; returns at the edge where the byte is taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = src_burst ? 0 : pick_gap();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		expect_result(deframe_byte(b));
		sent_bytes++;
	endtask

	task automatic send_frame(input logic [31:0] len, input logic [15:0] kind,
			input logic [15:0] version, input int payload_bytes);
		for (int i = 0; i < 4; i++)
			send_byte(len[8*i +: 8]);
		send_byte(kind[7:0]);
		send_byte(kind[15:8]);
		send_byte(version[7:0]);
		send_byte(version[15:8]);
		for (int i = 0; i < payload_bytes; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// sender stops until every pending result has drained
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_config(input logic [31:0] max_payload, input logic [15:0] kind_count);
		cfg_we <= 1'b1;
		cfg_index <= lpd_pkg::CFG_MAX_PAYLOAD;
		cfg_data <= max_payload;
		@(posedge clk);
		cfg_index <= lpd_pkg::CFG_KIND_COUNT;
		cfg_data <= {16'd0, kind_count};
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_max_payload = max_payload;
		reg_kind_count = kind_count;
	endtask

	task automatic test_directed_frames();
		send_frame(32'd0, 16'd0, 16'd0, 0);
		send_frame(32'd1, 16'd22, 16'hFFFF, 1);
		// kind equal to the default count reads back as invalid
		send_frame(32'd2, 16'd23, 16'h1234, 2);
	endtask

	task automatic test_kind_and_length_limits();
		settle();
		write_config(32'd0, 16'hFFFF);
		send_frame(32'd0, 16'hFFFE, 16'h00FF, 0);
		send_frame(32'd0, 16'hFFFF, 16'hFF00, 0);
		settle();
		write_config(32'd0, 16'd1);
		send_frame(32'd0, 16'd0, 16'h5A5A, 0);
		send_frame(32'd0, 16'd1, 16'hA5A5, 0);
		settle();
		write_config(32'hFFFF_FFFF, 16'hFFFF);
		send_frame(32'd3, 16'h8000, 16'h0001, 3);
		settle();
		// length equal to the limit is still legal
		write_config(32'd5, 16'd23);
		send_frame(32'd5, 16'd7, 16'd9, 5);
	endtask

	task automatic test_random_stream();
		logic [31:0] cap;
		logic [31:0] len;
		logic [31:0] max_payload;
		logic [15:0] kind;
		logic [15:0] kind_count;
		while (sent_bytes < RANDOM_BYTES) begin
			if ($urandom_range(0, 9) == 0) begin
				settle();
				case ($urandom_range(0, 3))
					0: max_payload = $urandom_range(0, 40);
					1: max_payload = 32'hFFFF_FFFF;
					2: max_payload = $urandom;
					default: max_payload = $urandom_range(41, 300);
				endcase
				case ($urandom_range(0, 3))
					0: kind_count = 16'd1;
					1: kind_count = 16'hFFFF;
					2: kind_count = 16'($urandom_range(1, 65535));
					default: kind_count = 16'($urandom_range(1, 30));
				endcase
				write_config(max_payload, kind_count);
			end
			src_burst = ($urandom_range(0, 4) == 0);
			cap = ($urandom_range(0, 9) == 0) ? 32'd300 : 32'd40;
			if (reg_max_payload < cap)
				cap = reg_max_payload;
			len = $urandom_range(0, cap);
			if ($urandom_range(0, 1) == 0)
				kind = 16'($urandom_range(0, reg_kind_count - 16'd1));
			else
				kind = 16'($urandom_range(0, 65535));
			send_frame(len, kind, 16'($urandom_range(0, 65535)), int'(len));
		end
		src_burst = 1'b0;
	endtask

	task automatic test_backpressure();
		settle();
		write_config(32'd64, 16'd23);
		src_burst = 1'b1;
		sink_hold = 80;
		for (int i = 0; i < 3; i++)
			send_frame(32'd10, 16'(i), 16'(16'h0100 + i), 10);
		settle();
		src_burst = 1'b0;
	endtask

	// fatal latches until reset, so this runs last
	task automatic test_fatal_length();
		settle();
		write_config(32'hFFFF_FFFE, 16'd23);
		send_frame(32'hFFFF_FFFF, 16'd5, 16'd7, 0);
		send_frame(32'd0, 16'd1, 16'd1, 0);
		for (int i = 0; i < 40; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// receiver: random stalls, steady stretches, and long hold-offs on request
	initial begin
		int stall_left;
		int steady_left;
		int r;
		stall_left = 0;
		steady_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				stall_left = sink_hold;
				sink_hold = 0;
				steady_left = 0;
			end else if (stall_left == 0 && steady_left > 0) begin
				steady_left--;
			end else if (stall_left == 0) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					steady_left = $urandom_range(50, 150);
				else if (r < 17)
					stall_left = $urandom_range(1, 3);
				else if (r < 19)
					stall_left = $urandom_range(8, 30);
			end
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		lpd_pkg::result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual byte %h status %h",
					$time, result_ch.out_byte, result_ch.status);
			end else begin
				want = expected_results.pop_front();
				check_field("status", 32'(want.status), 32'(result_ch.status));
				check_field("out_byte", 32'(want.out_byte), 32'(result_ch.out_byte));
				check_field("msg_kind", 32'(want.msg_kind), 32'(result_ch.msg_kind));
				check_field("frame_version", 32'(want.frame_version),
					32'(result_ch.frame_version));
				check_field("frame_length", want.frame_length, result_ch.frame_length);
				check_field("frame_end", 32'(want.frame_end), 32'(result_ch.frame_end));
			end
		end
	end

	// counts cycles in which neither side moves a request
	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("length_prefixed_deframer_test: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		errors = 0;
		sent_bytes = 0;
		quiet_cycles = 0;
		sink_hold = 0;
		src_burst = 1'b0;
		rx_hdr_count = '0;
		rx_hdr = '0;
		rx_left = '0;
		rx_in_payload = 1'b0;
		rx_fatal = 1'b0;
		reg_max_payload = lpd_pkg::MAX_PAYLOAD_RST;
		reg_kind_count = lpd_pkg::KIND_COUNT_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_kind_and_length_limits();
		test_random_stream();
		test_backpressure();
		test_fatal_length();
		settle();

		if (errors == 0)
			$display("length_prefixed_deframer_test: PASS");
		else
			$display("length_prefixed_deframer_test: FAIL");
		$finish;
	end

endmodule
